/* hdl/cc2a_pkg.sv */
// ----------------------------------------------------------------------------
// cc2a_pkg: shared types and constants for the console cell encoder
// Descriptor layout passed from the classifier to the byte sequencer.
// ----------------------------------------------------------------------------
package cc2a_pkg;

	localparam int unsigned NUM_SLOTS = 19;
	localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
	localparam int unsigned QDEPTH    = 2;

	// Byte slots of the emission template, in output order
	localparam logic [SLOT_W-1:0] SLOT_ESC     = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_LBR     = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_INT_A   = SLOT_W'(2);
	localparam logic [SLOT_W-1:0] SLOT_INT_B   = SLOT_W'(3);
	localparam logic [SLOT_W-1:0] SLOT_INT_SEP = SLOT_W'(4);
	localparam logic [SLOT_W-1:0] SLOT_FG_A    = SLOT_W'(5);
	localparam logic [SLOT_W-1:0] SLOT_FG_B    = SLOT_W'(6);
	localparam logic [SLOT_W-1:0] SLOT_FG_SEP  = SLOT_W'(7);
	localparam logic [SLOT_W-1:0] SLOT_BG_A    = SLOT_W'(8);
	localparam logic [SLOT_W-1:0] SLOT_BG_B    = SLOT_W'(9);
	localparam logic [SLOT_W-1:0] SLOT_BG_C    = SLOT_W'(10);
	localparam logic [SLOT_W-1:0] SLOT_BG_SEP  = SLOT_W'(11);
	localparam logic [SLOT_W-1:0] SLOT_U0      = SLOT_W'(12);
	localparam logic [SLOT_W-1:0] SLOT_U1      = SLOT_W'(13);
	localparam logic [SLOT_W-1:0] SLOT_U2      = SLOT_W'(14);
	localparam logic [SLOT_W-1:0] SLOT_U3      = SLOT_W'(15);
	localparam logic [SLOT_W-1:0] SLOT_C_ESC   = SLOT_W'(16);
	localparam logic [SLOT_W-1:0] SLOT_C_LBR   = SLOT_W'(17);
	localparam logic [SLOT_W-1:0] SLOT_C_M     = SLOT_W'(18);

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_3    = 8'h33;
	localparam logic [7:0] CH_4    = 8'h34;
	localparam logic [7:0] CH_9    = 8'h39;

	localparam logic [31:0] CP_ESC     = 32'h0000_001B;
	localparam logic [31:0] CP_REPL    = 32'h0000_FFFD;
	localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
	localparam logic [31:0] CP_SUR_LO  = 32'h0000_D800;
	localparam logic [31:0] CP_SUR_HI  = 32'h0000_DFFF;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;      // slots still to emit
		logic [SLOT_W-1:0]    term_slot; // separator that becomes 'm'
		logic [7:0]           attr;
		logic [3:0][7:0]      utf8;      // utf8[0] is emitted first
		logic                 line_end;
	} desc_t;

	// ANSI color digit: red (bit 2) weighs 1, green 2, blue (bit 0) 4
	function automatic logic [7:0] color_char(input logic [2:0] bgr);
		return CH_0 | {5'b0, bgr[0], bgr[1], bgr[2]};
	endfunction

endpackage

/* hdl/cc2a_if.sv */
// ----------------------------------------------------------------------------
// cc2a_if: valid/ready channels of the console cell encoder
// Cell input, byte output and configuration write channels.
// ----------------------------------------------------------------------------
interface cc2a_cell_if;
	logic        valid;
	logic        ready;
	logic [31:0] code_point;
	logic [15:0] cell_attributes;
	logic        line_end;

	modport source (output valid, code_point, cell_attributes, line_end, input ready);
	modport sink   (input valid, code_point, cell_attributes, line_end, output ready);
endinterface

interface cc2a_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       line_done;
	logic       last;

	modport source (output valid, out_byte, line_done, last, input ready);
	modport sink   (input valid, out_byte, line_done, last, output ready);
endinterface

interface cc2a_cfg_if;
	logic valid;
	logic ready;
	logic color_enable;

	modport source (output valid, color_enable, input ready);
	modport sink   (input valid, color_enable, output ready);
endinterface

/* hdl/cc2a_front.sv */
// ----------------------------------------------------------------------------
// cc2a_front: cell classifier
// Accepts cells, decides the SGR parts, encodes UTF-8, tracks line color state.
// ----------------------------------------------------------------------------
module cc2a_front (
	input  logic            clk,
	input  logic            arst_n,
	cc2a_cell_if.sink       cell_in,
	cc2a_cfg_if.sink        cfg,
	input  logic            q_full,
	output logic            push,
	output cc2a_pkg::desc_t desc
);
	import cc2a_pkg::*;

	logic        color_en_q;
	logic [7:0]  prev_attr_q;
	logic        prev_valid_q;

	logic [7:0]  now;
	logic [7:0]  diff;
	logic        first;
	logic        do_sgr, int_en, fg_en, bg_en, close_en;
	logic [31:0] cp;
	logic [3:0]  u_en;
	logic [3:0][7:0] u_bytes;

	assign cfg.ready     = 1'b1;
	assign cell_in.ready = !q_full;
	assign push          = cell_in.valid && !q_full;

	assign now   = cell_in.cell_attributes[7:0];
	assign diff  = now ^ prev_attr_q;
	assign first = !prev_valid_q;

	assign do_sgr   = color_en_q && (first || (diff != 8'h00));
	assign int_en   = do_sgr && (first || diff[3]);
	assign fg_en    = do_sgr && (first || (diff[3:0] != 4'h0));
	assign bg_en    = do_sgr && (first || (diff[7:4] != 4'h0));
	assign close_en = cell_in.line_end && (prev_valid_q || do_sgr);

	// replace ESC, surrogates and out-of-range values
	always_comb begin
		if (cell_in.code_point == CP_ESC || cell_in.code_point > CP_MAX ||
		    (cell_in.code_point >= CP_SUR_LO && cell_in.code_point <= CP_SUR_HI)) begin
			cp = CP_REPL;
		end else begin
			cp = cell_in.code_point;
		end
	end

	always_comb begin
		u_bytes = '0;
		if (cp < 32'h80) begin
			u_en       = 4'b0001;
			u_bytes[0] = cp[7:0];
		end else if (cp < 32'h800) begin
			u_en       = 4'b0011;
			u_bytes[0] = {3'b110, cp[10:6]};
			u_bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 32'h10000) begin
			u_en       = 4'b0111;
			u_bytes[0] = {4'b1110, cp[15:12]};
			u_bytes[1] = {2'b10, cp[11:6]};
			u_bytes[2] = {2'b10, cp[5:0]};
		end else begin
			u_en       = 4'b1111;
			u_bytes[0] = {5'b11110, cp[20:18]};
			u_bytes[1] = {2'b10, cp[17:12]};
			u_bytes[2] = {2'b10, cp[11:6]};
			u_bytes[3] = {2'b10, cp[5:0]};
		end
	end

	always_comb begin
		desc.mask = '0;
		desc.mask[SLOT_ESC]     = do_sgr;
		desc.mask[SLOT_LBR]     = do_sgr;
		desc.mask[SLOT_INT_A]   = int_en;
		desc.mask[SLOT_INT_B]   = int_en && !now[3];
		desc.mask[SLOT_INT_SEP] = int_en;
		desc.mask[SLOT_FG_A]    = fg_en;
		desc.mask[SLOT_FG_B]    = fg_en;
		desc.mask[SLOT_FG_SEP]  = fg_en;
		desc.mask[SLOT_BG_A]    = bg_en;
		desc.mask[SLOT_BG_B]    = bg_en && now[7];
		desc.mask[SLOT_BG_C]    = bg_en;
		desc.mask[SLOT_BG_SEP]  = bg_en;
		desc.mask[SLOT_U0]      = u_en[0];
		desc.mask[SLOT_U1]      = u_en[1];
		desc.mask[SLOT_U2]      = u_en[2];
		desc.mask[SLOT_U3]      = u_en[3];
		desc.mask[SLOT_C_ESC]   = close_en;
		desc.mask[SLOT_C_LBR]   = close_en;
		desc.mask[SLOT_C_M]     = close_en;
		if (bg_en) begin
			desc.term_slot = SLOT_BG_SEP;
		end else if (fg_en) begin
			desc.term_slot = SLOT_FG_SEP;
		end else begin
			desc.term_slot = SLOT_INT_SEP;
		end
		desc.attr     = now;
		desc.utf8     = u_bytes;
		desc.line_end = cell_in.line_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_en_q   <= 1'b1;
			prev_attr_q  <= 8'h00;
			prev_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				color_en_q <= cfg.color_enable;
			end
			if (push) begin
				if (do_sgr) begin
					prev_attr_q <= now;
				end
				prev_valid_q <= (prev_valid_q || do_sgr) && !cell_in.line_end;
			end
		end
	end

endmodule

/* hdl/cc2a_queue.sv */
// ----------------------------------------------------------------------------
// cc2a_queue: descriptor queue
// Short first-in first-out buffer between classifier and sequencer.
// ----------------------------------------------------------------------------
module cc2a_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cc2a_pkg::desc_t wr_desc,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output cc2a_pkg::desc_t head
);
	import cc2a_pkg::*;

	localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	desc_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hdl/cc2a_back.sv */
// ----------------------------------------------------------------------------
// cc2a_back: byte sequencer
// Walks the enabled slots of each descriptor, one byte per ready cycle.
// ----------------------------------------------------------------------------
module cc2a_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  cc2a_pkg::desc_t head,
	output logic            pop,
	cc2a_byte_if.source     byte_out
);
	import cc2a_pkg::*;

	desc_t                cur_desc_q;
	logic [NUM_SLOTS-1:0] cur_mask_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 line_done_q;
	logic                 last_q;

	logic                 advance, busy, have;
	desc_t                eff;
	logic [NUM_SLOTS-1:0] eff_mask, remain;
	logic [SLOT_W-1:0]    slot;
	logic [7:0]           bval;

	assign advance = !out_valid_q || byte_out.ready;
	assign busy    = (cur_mask_q != '0);
	assign eff     = busy ? cur_desc_q : head;
	assign eff_mask = busy ? cur_mask_q : (head_valid ? head.mask : '0);
	assign have    = (eff_mask != '0);
	assign pop     = advance && !busy && head_valid;

	// lowest pending slot
	always_comb begin
		slot = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (eff_mask[i]) begin
				slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		remain       = eff_mask;
		remain[slot] = 1'b0;
	end

	always_comb begin
		unique case (slot)
			SLOT_ESC, SLOT_C_ESC:  bval = CH_ESC;
			SLOT_LBR, SLOT_C_LBR:  bval = CH_LBR;
			SLOT_C_M:              bval = CH_M;
			SLOT_INT_A:            bval = eff.attr[3] ? CH_1 : CH_2;
			SLOT_INT_B:            bval = CH_2;
			SLOT_FG_A:             bval = eff.attr[3] ? CH_9 : CH_3;
			SLOT_FG_B:             bval = color_char(eff.attr[2:0]);
			SLOT_BG_A:             bval = eff.attr[7] ? CH_1 : CH_4;
			SLOT_BG_B:             bval = CH_0;
			SLOT_BG_C:             bval = color_char(eff.attr[6:4]);
			SLOT_INT_SEP, SLOT_FG_SEP, SLOT_BG_SEP:
				bval = (slot == eff.term_slot) ? CH_M : CH_SEMI;
			SLOT_U0:               bval = eff.utf8[0];
			SLOT_U1:               bval = eff.utf8[1];
			SLOT_U2:               bval = eff.utf8[2];
			SLOT_U3:               bval = eff.utf8[3];
			default:               bval = CH_SEMI;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance && !busy && head_valid) begin
			cur_desc_q <= head;
		end
		if (advance && have) begin
			out_byte_q  <= bval;
			last_q      <= (remain == '0);
			line_done_q <= (remain == '0) && eff.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= have;
			if (have) begin
				cur_mask_q <= remain;
			end
		end
	end

	assign byte_out.valid     = out_valid_q;
	assign byte_out.out_byte  = out_byte_q;
	assign byte_out.line_done = line_done_q;
	assign byte_out.last      = last_q;

endmodule

/* hdl/console_cell_to_ansi_utf8_core.sv */
// The first byte of a cell passes the descriptor queue and the sequencer's output register.
// Throughput: one output byte per cycle while the byte sink is ready; a cell holds the
// sequencer until its 1 to 19 bytes (typically 1 to 4) leave the one-byte output port.
// Cells are taken back to back while the two-entry descriptor queue has room.
// Reset (arst_n low, asynchronous): color enabled, line color state cleared, queue and
// output emptied.
// ----------------------------------------------------------------------------
// console_cell_to_ansi_utf8_core: console cell to ANSI SGR and UTF-8 byte stream
// Classifier, descriptor queue and byte sequencer.
// ----------------------------------------------------------------------------
module console_cell_to_ansi_utf8_core (
	input  logic        clk,
	input  logic        arst_n,
	cc2a_cell_if.sink   cell_in,
	cc2a_cfg_if.sink    cfg,
	cc2a_byte_if.source byte_out
);
	import cc2a_pkg::*;

	desc_t wr_desc;
	desc_t head;
	logic  push, pop, q_full, head_valid;

	// Front: classify each cell transaction into a slot descriptor and
	// advance the per-line color state at acceptance time, so the next cell
	// can be classified in the following cycle.
	cc2a_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cell_in (cell_in),
		.cfg     (cfg),
		.q_full  (q_full),
		.push    (push),
		.desc    (wr_desc)
	);

	// Queue: hold descriptors so a stalled byte sink does not stall intake
	// until the queue fills.
	cc2a_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_desc    (wr_desc),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back: drop each emitted slot from the mask, and move straight to the
	// next descriptor when the current one runs out, without a bubble.
	cc2a_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.byte_out   (byte_out)
	);

endmodule

/* test/console_cell_to_ansi_utf8_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_cell_to_ansi_utf8_core_tb: self-checking bench for the cell encoder
// Feeds console cells through the cell channel, switches the color enable
// between phases and compares every output byte with a cycle-free model.
// ----------------------------------------------------------------------------
module console_cell_to_ansi_utf8_core_tb;
	import cc2a_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_CELLS = 210;
	localparam int IDLE_PCT     = 19;
	localparam int SETTLE       = 6;       // sequencer latency plus margin
	localparam int CYCLE_LIMIT  = 200_000;

	// One encoded byte as it should leave the block
	typedef struct {
		logic [7:0] data;
		logic       line_done;
		logic       last;
	} enc_byte_t;

	// Rows of the directed table: either a cell or a color enable write
	typedef enum logic {ROW_CELL, ROW_COLOR} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] cp;
		logic [15:0] attr;
		logic        eol;
		logic        color;
	} dir_row_t;

	localparam int NUM_DIR = 26;

	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		'{ROW_CELL,  32'h0000_0041, 16'h0007, 1'b0, 1'b0}, // first cell after reset
		'{ROW_CELL,  32'h0000_007F, 16'h0007, 1'b0, 1'b0}, // same color, top of ASCII
		'{ROW_CELL,  32'h0000_0080, 16'hFF0F, 1'b0, 1'b0}, // intensity + fg change
		'{ROW_CELL,  32'h0000_07FF, 16'h00F0, 1'b0, 1'b0}, // everything changes
		'{ROW_CELL,  32'h0000_0800, 16'h00F0, 1'b1, 1'b0}, // line end, closing SGR
		'{ROW_CELL,  32'h0000_0000, 16'h0000, 1'b0, 1'b0}, // null character
		'{ROW_CELL,  32'h0000_001B, 16'h0000, 1'b0, 1'b0}, // ESC is replaced
		'{ROW_CELL,  32'h0000_D800, 16'h0080, 1'b0, 1'b0}, // low surrogate edge
		'{ROW_CELL,  32'h0000_DFFF, 16'h0080, 1'b0, 1'b0}, // high surrogate edge
		'{ROW_CELL,  32'h0000_D7FF, 16'h0008, 1'b0, 1'b0},
		'{ROW_CELL,  32'h0000_E000, 16'hFFFF, 1'b0, 1'b0},
		'{ROW_CELL,  32'h0000_FFFF, 16'h0070, 1'b0, 1'b0},
		'{ROW_CELL,  32'h0001_0000, 16'h0070, 1'b0, 1'b0},
		'{ROW_CELL,  32'h0010_FFFF, 16'h8000, 1'b0, 1'b0}, // high byte is ignored
		'{ROW_CELL,  32'h0011_0000, 16'h0000, 1'b0, 1'b0}, // just above the range
		'{ROW_CELL,  32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b0},
		'{ROW_CELL,  32'h0000_0041, 16'hFFFF, 1'b1, 1'b0}, // all-ones attribute
		'{ROW_COLOR, 32'h0,         16'h0,    1'b0, 1'b0},
		'{ROW_CELL,  32'h0000_0042, 16'h0055, 1'b0, 1'b0}, // plain text only
		'{ROW_COLOR, 32'h0,         16'h0,    1'b0, 1'b1},
		'{ROW_CELL,  32'h0000_0043, 16'h0055, 1'b0, 1'b0},
		'{ROW_COLOR, 32'h0,         16'h0,    1'b0, 1'b0}, // color off mid-line
		'{ROW_CELL,  32'h0000_0044, 16'h00AA, 1'b1, 1'b0}, // reset still closes line
		'{ROW_CELL,  32'h0000_0045, 16'h0000, 1'b1, 1'b0}, // nothing to close
		'{ROW_COLOR, 32'h0,         16'h0,    1'b0, 1'b1},
		'{ROW_CELL,  32'h0000_0046, 16'h0001, 1'b1, 1'b0}
	};

	// Byte strings that can be read straight off the encoding rules; an empty
	// entry leaves the row to the predictor.
	string dir_text [NUM_DIR] = '{
		"\033[22;37;40mA", "", "", "", "", "", "", "", "", "", "", "", "", "",
		"", "", "\033[1;97;107mA\033[m", "", "B", "", "\033[22;35;45mC", "",
		"D\033[m", "E", "", "\033[22;34;40mF\033[m"
	};

	logic clk;
	logic arst_n;

	cc2a_cell_if cell_ch ();
	cc2a_cfg_if  cfg_ch ();
	cc2a_byte_if byte_ch ();

	console_cell_to_ansi_utf8_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cell_in  (cell_ch),
		.cfg      (cfg_ch),
		.byte_out (byte_ch)
	);

	// Predictor state: a private copy of the line color memory and the register
	logic [7:0] line_attr;
	logic       line_colored;
	logic       color_on;

	logic [7:0] cell_bytes[$];     // bytes of the cell being predicted
	enc_byte_t  expected_bytes[$]; // bytes still owed by the block
	enc_byte_t  owed;

	int  mismatches;
	int  cycle_count;
	bit  gaps_on;

	// ------------------------------------------------------------------------
	// Clock and cycle limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Bail out if the block hangs; a correct run stays far below this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// ANSI digit: red weighs 1, green 2, blue 4; attribute order is B, G, R
	function automatic logic [7:0] ansi_digit_char(input logic [2:0] bgr);
		logic [2:0] rgb;
		rgb = {bgr[0], bgr[1], bgr[2]};
		return CH_0 + {5'b0, rgb};
	endfunction

	// Work out the byte stream of one cell and advance the line color memory
	function automatic void encode_cell(input logic [31:0] cp, input logic [7:0] attr,
			input logic eol);
		logic        first;
		logic [7:0]  diff;
		logic [31:0] ch;
		cell_bytes.delete();

		// SGR sequence when colored and the attribute byte is new for the line
		if (color_on && (!line_colored || attr != line_attr)) begin
			first = !line_colored;
			diff  = attr ^ line_attr;
			cell_bytes.push_back(CH_ESC);
			cell_bytes.push_back(CH_LBR);
			if (first || diff[3]) begin
				if (attr[3]) begin
					cell_bytes.push_back(CH_1);
				end else begin
					cell_bytes.push_back(CH_2);
					cell_bytes.push_back(CH_2);
				end
				cell_bytes.push_back(CH_SEMI);
			end
			if (first || diff[3:0] != 4'd0) begin
				cell_bytes.push_back(attr[3] ? CH_9 : CH_3);
				cell_bytes.push_back(ansi_digit_char(attr[2:0]));
				cell_bytes.push_back(CH_SEMI);
			end
			if (first || diff[7:4] != 4'd0) begin
				if (attr[7]) begin
					cell_bytes.push_back(CH_1);
					cell_bytes.push_back(CH_0);
				end else begin
					cell_bytes.push_back(CH_4);
				end
				cell_bytes.push_back(ansi_digit_char(attr[6:4]));
				cell_bytes.push_back(CH_SEMI);
			end
			// the trailing separator turns into the terminator
			cell_bytes[cell_bytes.size() - 1] = CH_M;
			line_attr    = attr;
			line_colored = 1'b1;
		end

		// UTF-8 of the character, with ESC and invalid values replaced
		ch = cp;
		if (cp == CP_ESC || cp > CP_MAX || (cp >= CP_SUR_LO && cp <= CP_SUR_HI))
			ch = CP_REPL;
		if (ch < 32'h80) begin
			cell_bytes.push_back(ch[7:0]);
		end else if (ch < 32'h800) begin
			cell_bytes.push_back({3'b110, ch[10:6]});
			cell_bytes.push_back({2'b10, ch[5:0]});
		end else if (ch < 32'h10000) begin
			cell_bytes.push_back({4'b1110, ch[15:12]});
			cell_bytes.push_back({2'b10, ch[11:6]});
			cell_bytes.push_back({2'b10, ch[5:0]});
		end else begin
			cell_bytes.push_back({5'b11110, ch[20:18]});
			cell_bytes.push_back({2'b10, ch[17:12]});
			cell_bytes.push_back({2'b10, ch[11:6]});
			cell_bytes.push_back({2'b10, ch[5:0]});
		end

		// Close the line's color even if the register went low meanwhile
		if (eol) begin
			if (line_colored) begin
				cell_bytes.push_back(CH_ESC);
				cell_bytes.push_back(CH_LBR);
				cell_bytes.push_back(CH_M);
			end
			line_colored = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus tasks
	// ------------------------------------------------------------------------

	// Offer one cell, hold it until the transaction, then queue its bytes.
	// A non-empty byte string overrides the predicted bytes for that cell.
	task automatic send_cell(input logic [31:0] cp, input logic [15:0] attr,
			input logic eol, input string typed);
		int        n;
		enc_byte_t b;
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			cell_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cell_ch.valid           <= 1'b1;
		cell_ch.code_point      <= cp;
		cell_ch.cell_attributes <= attr;
		cell_ch.line_end        <= eol;
		@(posedge clk);
		while (!cell_ch.ready) @(posedge clk);

		encode_cell(cp, attr[7:0], eol);
		if (typed.len() != 0) begin
			cell_bytes.delete();
			for (int i = 0; i < typed.len(); i++)
				cell_bytes.push_back(typed.getc(i));
		end
		n = cell_bytes.size();
		for (int i = 0; i < n; i++) begin
			b.data      = cell_bytes[i];
			b.last      = (i == n - 1);
			b.line_done = eol && (i == n - 1);
			expected_bytes.push_back(b);
		end
	endtask

	// Drop the cell channel and wait until every owed byte has come out
	task automatic drain();
		cell_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the color enable register; call only while the block is idle
	task automatic write_color_enable(input logic en);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.color_enable <= en;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		color_on = en;
		cfg_ch.valid <= 1'b0;
	endtask

	// Code point spread over every UTF-8 length and every replaced class
	function automatic logic [31:0] pick_code_point();
		case ($urandom_range(11))
			0, 1, 2: return 32'($urandom_range(32'h7F));
			3:       return 32'($urandom_range(32'h7FF, 32'h80));
			4:       return 32'($urandom_range(32'hFFFF, 32'h800));
			5:       return 32'($urandom_range(32'h10FFFF, 32'h10000));
			6:       return 32'($urandom_range(CP_SUR_HI, CP_SUR_LO));
			7:       return CP_ESC;
			8:       return 32'($urandom_range(32'hFFFF_FFFF, 32'h11_0000));
			9:       return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Byte sink: random stalls on ready, then check each transaction
	// ------------------------------------------------------------------------
	initial begin
		byte_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			byte_ch.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
			@(posedge clk);
		end
	end

	// Compare every accepted byte with the oldest owed byte
	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte, expected none, actual %h ld=%b last=%b",
					$time, byte_ch.out_byte, byte_ch.line_done, byte_ch.last);
				mismatches++;
			end else begin
				owed = expected_bytes[0];
				expected_bytes.delete(0);
				if (byte_ch.out_byte !== owed.data || byte_ch.line_done !== owed.line_done ||
						byte_ch.last !== owed.last) begin
					$display("%0t: byte mismatch, expected %h ld=%b last=%b, actual %h ld=%b last=%b",
						$time, owed.data, owed.line_done, owed.last,
						byte_ch.out_byte, byte_ch.line_done, byte_ch.last);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence: reset, directed table, random lines, wind-down
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0]  palette [4];
		logic [15:0] attr;
		logic        eol;
		int          line_len;
		int          random_cells;

		// Hold every input at a known value and keep the block in reset
		arst_n                  = 1'b0;
		cell_ch.valid           = 1'b0;
		cell_ch.code_point      = '0;
		cell_ch.cell_attributes = '0;
		cell_ch.line_end        = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.color_enable     = 1'b1;
		mismatches              = 0;
		cycle_count             = 0;
		gaps_on                 = 1'b1;
		random_cells            = 0;

		// Predictor comes out of reset as the block does: color on, line clean
		color_on     = 1'b1;
		line_attr    = 8'h00;
		line_colored = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; register writes only with the block idle
		for (int r = 0; r < NUM_DIR; r++) begin
			if (DIR_ROWS[r].kind == ROW_COLOR) begin
				drain();
				write_color_enable(DIR_ROWS[r].color);
			end else begin
				send_cell(DIR_ROWS[r].cp, DIR_ROWS[r].attr, DIR_ROWS[r].eol, dir_text[r]);
			end
		end

		// Random lines: a small palette per line so that the attribute both
		// repeats (no SGR) and changes partially; the high byte is noise.
		while (random_cells < RANDOM_CELLS) begin
			foreach (palette[i]) palette[i] = 8'($urandom());
			line_len = $urandom_range(12, 1);
			for (int k = 0; k < line_len; k++) begin
				// advance into a stretch without any idling on either side
				if (random_cells == 90)  gaps_on <= 1'b0;
				if (random_cells == 150) gaps_on <= 1'b1;
				if ($urandom_range(9) < 8)
					attr = {8'($urandom()), palette[$urandom_range(3)]};
				else
					attr = 16'($urandom());
				// mostly whole lines, now and then a line cut short
				eol = (k == line_len - 1) || ($urandom_range(19) == 0);
				send_cell(pick_code_point(), attr, eol, "");
				random_cells++;
				// flip the color enable now and then, mid-line or at line end
				if ($urandom_range(24) == 0) begin
					drain();
					write_color_enable(!color_on);
				end
			end
		end

		// Wind down: every owed byte out, then a settling wait for strays
		drain();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
